### design/tlppc_pkg.sv
package tlppc_pkg;

    localparam int ACC_W = 15;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t ACC_MAX = 15'sd16383;

    localparam logic [7:0] CHAR_START = 8'h69;
    localparam logic [7:0] CHAR_END   = 8'h23;
    localparam logic [7:0] CHAR_SEP   = 8'h24;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] FIELD_DIST  = 2'd0;
    localparam logic [1:0] FIELD_TEMP  = 2'd1;
    localparam logic [1:0] FIELD_CHECK = 2'd2;
    localparam logic [1:0] FIELD_DONE  = 2'd3;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [2:0] CFG_POLL_PERIOD = 3'd0;
    localparam logic [2:0] CFG_PUMP_MAX    = 3'd1;
    localparam logic [2:0] CFG_LOW_LEVEL   = 3'd2;
    localparam logic [2:0] CFG_FULL_LEVEL  = 3'd3;
    localparam logic [2:0] CFG_FAIL_LIMIT  = 3'd4;

    typedef struct packed {
        logic complete;
        acc_t distance;
        acc_t temperature;
        acc_t check;
    } frame_t;

endpackage

### design/tlppc_frame_parser.sv
module tlppc_frame_parser #(
    parameter int FIELD_CHARS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_en,
    input  logic [7:0]        rx_byte,
    output tlppc_pkg::frame_t frame
);

    localparam int DIGIT_W = $clog2(FIELD_CHARS + 1);
    localparam int PROD_W  = tlppc_pkg::ACC_W + 4;

    logic [1:0]         field_index_reg, field_index_next;
    tlppc_pkg::acc_t    distance_acc_reg, distance_acc_next;
    tlppc_pkg::acc_t    temperature_acc_reg, temperature_acc_next;
    tlppc_pkg::acc_t    check_acc_reg, check_acc_next;
    logic [DIGIT_W-1:0] field_digits_reg, field_digits_next;
    logic               field_negative_reg, field_negative_next;
    logic               field_stopped_reg, field_stopped_next;

    tlppc_pkg::acc_t          cur_acc;
    tlppc_pkg::acc_t          new_acc;
    logic [tlppc_pkg::ACC_W-1:0] cur_mag;
    logic [PROD_W-1:0]        prod;
    logic                     is_digit;
    logic                     write_acc;

    always_comb begin
        case (field_index_reg)
            tlppc_pkg::FIELD_DIST: cur_acc = distance_acc_reg;
            tlppc_pkg::FIELD_TEMP: cur_acc = temperature_acc_reg;
            default:               cur_acc = check_acc_reg;
        endcase
    end

    assign cur_mag  = cur_acc;
    assign is_digit = (rx_byte >= tlppc_pkg::CHAR_ZERO) && (rx_byte <= tlppc_pkg::CHAR_NINE);
    assign prod     = (PROD_W'(cur_mag) << 3) + (PROD_W'(cur_mag) << 1)
                    + PROD_W'(rx_byte[3:0]);

    always_comb begin
        field_index_next     = field_index_reg;
        distance_acc_next    = distance_acc_reg;
        temperature_acc_next = temperature_acc_reg;
        check_acc_next       = check_acc_reg;
        field_digits_next    = field_digits_reg;
        field_negative_next  = field_negative_reg;
        field_stopped_next   = field_stopped_reg;
        new_acc              = cur_acc;
        write_acc            = 1'b0;

        if (byte_en) begin
            if ((rx_byte == tlppc_pkg::CHAR_END) || (rx_byte == tlppc_pkg::CHAR_START)) begin
                field_index_next     = tlppc_pkg::FIELD_DIST;
                distance_acc_next    = '0;
                temperature_acc_next = '0;
                check_acc_next       = '0;
                field_digits_next    = '0;
                field_negative_next  = 1'b0;
                field_stopped_next   = 1'b0;
            end else if (field_index_reg != tlppc_pkg::FIELD_DONE) begin
                if (rx_byte == tlppc_pkg::CHAR_SEP) begin
                    new_acc             = field_negative_reg ? -cur_acc : cur_acc;
                    write_acc           = 1'b1;
                    field_index_next    = field_index_reg + 2'd1;
                    field_digits_next   = '0;
                    field_negative_next = 1'b0;
                    field_stopped_next  = 1'b0;
                end else if (!field_stopped_reg) begin
                    if (is_digit) begin
                        if (field_digits_reg < DIGIT_W'(FIELD_CHARS)) begin
                            new_acc = (prod > PROD_W'(tlppc_pkg::ACC_MAX))
                                    ? tlppc_pkg::ACC_MAX
                                    : tlppc_pkg::acc_t'(prod[tlppc_pkg::ACC_W-1:0]);
                            write_acc         = 1'b1;
                            field_digits_next = field_digits_reg + DIGIT_W'(1);
                        end
                    end else if ((rx_byte == tlppc_pkg::CHAR_MINUS)
                                 && (field_digits_reg == '0) && !field_negative_reg) begin
                        field_negative_next = 1'b1;
                    end else begin
                        field_stopped_next = 1'b1;
                    end
                end
                if (write_acc) begin
                    case (field_index_reg)
                        tlppc_pkg::FIELD_DIST: distance_acc_next    = new_acc;
                        tlppc_pkg::FIELD_TEMP: temperature_acc_next = new_acc;
                        default:               check_acc_next       = new_acc;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg     <= tlppc_pkg::FIELD_DIST;
            distance_acc_reg    <= '0;
            temperature_acc_reg <= '0;
            check_acc_reg       <= '0;
            field_digits_reg    <= '0;
            field_negative_reg  <= 1'b0;
            field_stopped_reg   <= 1'b0;
        end else begin
            field_index_reg     <= field_index_next;
            distance_acc_reg    <= distance_acc_next;
            temperature_acc_reg <= temperature_acc_next;
            check_acc_reg       <= check_acc_next;
            field_digits_reg    <= field_digits_next;
            field_negative_reg  <= field_negative_next;
            field_stopped_reg   <= field_stopped_next;
        end
    end

    assign frame.complete    = byte_en && (rx_byte == tlppc_pkg::CHAR_END)
                             && (field_index_reg == tlppc_pkg::FIELD_DONE);
    assign frame.distance    = distance_acc_reg;
    assign frame.temperature = temperature_acc_reg;
    assign frame.check       = check_acc_reg;

endmodule

### design/tank_level_pump_poll_controller.sv
// Tank level pump poll controller. Each input transaction is a timer tick (s_cmd = 0) or a
// received serial byte (s_cmd = 1), and each one yields exactly one result transaction.
// Ticks advance the poll timer (status request every poll_period ticks), the unanswered-poll
// counter (link error once it reaches fail_limit) and the pump run timer (relay opened after
// pump_max_ticks). Bytes are parsed as frames 'i' dist '$' temp '$' check '$' '#'; a frame
// whose check equals dist+temp switches the pump against low_level and full_level, otherwise
// a re-poll is requested. The block takes one transaction per clock cycle while m_ready keeps
// up; each one passes the input register and then the result register. While a finished result
// waits for m_ready the input register can still take one more transaction. Configuration
// writes are taken on any cycle and must be issued only while no transaction is in flight.
module tank_level_pump_poll_controller #(
    parameter int FIELD_CHARS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_poll,
    output logic        m_relay_closed,
    output logic        m_blink_single,
    output logic        m_blink_double,
    output logic        m_blink_error,
    output logic [1:0]  m_frame_status
);

    logic [15:0]     poll_period_reg;
    logic [15:0]     pump_max_ticks_reg;
    tlppc_pkg::acc_t low_level_reg;
    tlppc_pkg::acc_t full_level_reg;
    logic [2:0]      fail_limit_reg;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;

    logic [15:0] poll_timer_reg, poll_timer_next;
    logic [15:0] run_timer_reg, run_timer_next;
    logic [2:0]  unanswered_reg, unanswered_next;
    logic        pump_flag_reg, pump_flag_next;
    logic        relay_state_reg, relay_state_next;

    logic        out_valid_reg;
    logic        send_poll_reg, send_poll_next;
    logic        relay_closed_reg;
    logic        blink_single_reg, blink_single_next;
    logic        blink_double_reg, blink_double_next;
    logic        blink_error_reg, blink_error_next;
    logic [1:0]  frame_status_reg, frame_status_next;

    logic        out_free;
    logic        consume;
    logic        byte_en;
    logic [2:0]  una_after_err;
    logic [15:0] poll_inc;
    logic [15:0] run_inc;
    logic signed [tlppc_pkg::ACC_W:0] check_sum;

    tlppc_pkg::frame_t frame;

    assign out_free  = !out_valid_reg || m_ready;
    assign consume   = in_valid_reg && out_free;
    assign byte_en   = consume && in_cmd_reg;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    tlppc_frame_parser #(
        .FIELD_CHARS(FIELD_CHARS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_period_reg    <= 16'd300;
            pump_max_ticks_reg <= 16'd18000;
            low_level_reg      <= 15'sd50;
            full_level_reg     <= 15'sd15;
            fail_limit_reg     <= 3'd3;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                tlppc_pkg::CFG_POLL_PERIOD: poll_period_reg    <= cfg_wdata;
                tlppc_pkg::CFG_PUMP_MAX:    pump_max_ticks_reg <= cfg_wdata;
                tlppc_pkg::CFG_LOW_LEVEL:   low_level_reg      <= cfg_wdata[14:0];
                tlppc_pkg::CFG_FULL_LEVEL:  full_level_reg     <= cfg_wdata[14:0];
                tlppc_pkg::CFG_FAIL_LIMIT:  fail_limit_reg     <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_rx_byte;
        end
    end

    assign poll_inc  = (poll_timer_reg == 16'hFFFF) ? poll_timer_reg : poll_timer_reg + 16'd1;
    assign run_inc   = (run_timer_reg == 16'hFFFF) ? run_timer_reg : run_timer_reg + 16'd1;
    assign check_sum = (tlppc_pkg::ACC_W+1)'(frame.distance)
                     + (tlppc_pkg::ACC_W+1)'(frame.temperature);

    always_comb begin
        poll_timer_next   = poll_timer_reg;
        run_timer_next    = run_timer_reg;
        unanswered_next   = unanswered_reg;
        pump_flag_next    = pump_flag_reg;
        relay_state_next  = relay_state_reg;
        send_poll_next    = 1'b0;
        blink_single_next = 1'b0;
        blink_double_next = 1'b0;
        blink_error_next  = 1'b0;
        frame_status_next = tlppc_pkg::STATUS_NONE;
        una_after_err     = unanswered_reg;

        if (consume && !in_cmd_reg) begin
            if (unanswered_reg >= fail_limit_reg) begin
                blink_error_next = 1'b1;
                una_after_err    = (fail_limit_reg != 3'd0) ? fail_limit_reg - 3'd1 : 3'd0;
            end
            unanswered_next = una_after_err;
            poll_timer_next = poll_inc;
            if (poll_inc >= poll_period_reg) begin
                send_poll_next    = 1'b1;
                blink_double_next = 1'b1;
                poll_timer_next   = '0;
                if (una_after_err != 3'd7) begin
                    unanswered_next = una_after_err + 3'd1;
                end
            end
            run_timer_next = run_inc;
            if ((run_inc >= pump_max_ticks_reg) && pump_flag_reg) begin
                relay_state_next = 1'b0;
            end
        end else if (byte_en) begin
            unanswered_next = '0;
            if (frame.complete) begin
                if ((tlppc_pkg::ACC_W+1)'(frame.check) != check_sum) begin
                    send_poll_next    = 1'b1;
                    blink_double_next = 1'b1;
                    poll_timer_next   = '0;
                    frame_status_next = tlppc_pkg::STATUS_MISMATCH;
                end else begin
                    frame_status_next = tlppc_pkg::STATUS_ACCEPT;
                    if (frame.distance <= low_level_reg) begin
                        blink_single_next = 1'b1;
                        relay_state_next  = 1'b1;
                        if (!pump_flag_reg) begin
                            pump_flag_next = 1'b1;
                            run_timer_next = '0;
                        end
                    end else if (frame.distance >= full_level_reg) begin
                        relay_state_next = 1'b0;
                        pump_flag_next   = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_timer_reg  <= '0;
            run_timer_reg   <= '0;
            unanswered_reg  <= '0;
            pump_flag_reg   <= 1'b0;
            relay_state_reg <= 1'b0;
        end else begin
            poll_timer_reg  <= poll_timer_next;
            run_timer_reg   <= run_timer_next;
            unanswered_reg  <= unanswered_next;
            pump_flag_reg   <= pump_flag_next;
            relay_state_reg <= relay_state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            send_poll_reg    <= send_poll_next;
            relay_closed_reg <= relay_state_next;
            blink_single_reg <= blink_single_next;
            blink_double_reg <= blink_double_next;
            blink_error_reg  <= blink_error_next;
            frame_status_reg <= frame_status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_send_poll    = send_poll_reg;
    assign m_relay_closed = relay_closed_reg;
    assign m_blink_single = blink_single_reg;
    assign m_blink_double = blink_double_reg;
    assign m_blink_error  = blink_error_reg;
    assign m_frame_status = frame_status_reg;

endmodule
